/* rtl/core/lhc_pkg.sv */
`timescale 1ns / 1ps
package lhc_pkg;

    // Field widths
    localparam int KEY_W      = 15;
    localparam int CNT_W      = 16;
    localparam int OUT_IDX_W  = 10;
    localparam int PROD_W     = 2 * KEY_W;

    // Defaults for the top-level parameters
    localparam int DEF_ENTRY_COUNT      = 1024;
    localparam int DEF_BUCKET_COUNT     = 31;
    localparam int DEF_SLOTS_PER_BUCKET = 64;

    // Reset values
    localparam logic [CNT_W-1:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [CNT_W-1:0] RESET_COUNT    = 16'd314;
    localparam int               RESET_DEP_STEP = 17;
    localparam logic [CNT_W-1:0] RESET_LIMIT    = 16'h8FFF;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT,
        OP_LOAD,
        OP_MOD_OLD,
        OP_BKT_NEW,
        OP_BKT_OLD,
        OP_RD_NEW,
        OP_RD_OLD,
        OP_ENT_RD,
        OP_NEXT,
        OP_HIT,
        OP_VINIT,
        OP_VSCAN,
        OP_UNMAP,
        OP_REKEY,
        OP_MAP,
        OP_FAIL,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic mod_done;
        logic slot_last;
        logic slot_valid;
        logic key_match;
        logic idx_match;
        logic ent_last;
        logic have_victim;
        logic out_free;
    } sts_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

endpackage

/* rtl/core/lhc_mod.sv */
`timescale 1ns / 1ps
module lhc_mod #(
    parameter int BUCKET_COUNT = lhc_pkg::DEF_BUCKET_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lhc_pkg::PROD_W-1:0]      operand,
    output logic                            done,
    output logic [$clog2(BUCKET_COUNT)-1:0] result
);
    import lhc_pkg::*;

    localparam int BKT_W = $clog2(BUCKET_COUNT);
    localparam int S1    = KEY_W + BKT_W;
    localparam int T_W   = 2 * BKT_W;
    localparam int S2    = T_W + BKT_W;
    localparam int P1_W  = KEY_W + S1;
    localparam int P2_W  = T_W + S2;

    // Reciprocals exact over the whole input range, and 2^KEY_W folded into the bucket range
    localparam longint unsigned M1   = ((64'd1 << S1) + BUCKET_COUNT - 1) / BUCKET_COUNT;
    localparam longint unsigned M2   = ((64'd1 << S2) + BUCKET_COUNT - 1) / BUCKET_COUNT;
    localparam longint unsigned FOLD = (64'd1 << KEY_W) % BUCKET_COUNT;

    logic [PROD_W-1:0] x_reg;
    logic [KEY_W-1:0]  qhi_reg;
    logic [KEY_W-1:0]  qlo_reg;
    logic [BKT_W-1:0]  rhi_reg;
    logic [BKT_W-1:0]  rlo_reg;
    logic [T_W-1:0]    t_reg;
    logic [T_W-1:0]    qt_reg;
    logic [BKT_W-1:0]  rem_reg;
    logic [4:0]        stage_reg;
    logic              done_reg;
    logic [P1_W-1:0]   prod_hi;
    logic [P1_W-1:0]   prod_lo;
    logic [KEY_W-1:0]  rhi_full;
    logic [KEY_W-1:0]  rlo_full;
    logic [T_W-1:0]    t_sum;
    logic [P2_W-1:0]   prod_t;
    logic [T_W-1:0]    rt_full;

    // Split the product into halves, reduce each, fold and reduce again
    always_comb
    begin
        prod_hi  = P1_W'(x_reg[PROD_W-1:KEY_W]) * P1_W'(M1);
        prod_lo  = P1_W'(x_reg[KEY_W-1:0]) * P1_W'(M1);
        rhi_full = x_reg[PROD_W-1:KEY_W] - qhi_reg * KEY_W'(BUCKET_COUNT);
        rlo_full = x_reg[KEY_W-1:0] - qlo_reg * KEY_W'(BUCKET_COUNT);
        t_sum    = T_W'(rhi_reg) * T_W'(FOLD) + T_W'(rlo_reg);
        prod_t   = P2_W'(t_reg) * P2_W'(M2);
        rt_full  = t_reg - qt_reg * T_W'(BUCKET_COUNT);
    end

    // Track the word through the five stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            stage_reg <= 5'b00001;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[3:0], 1'b0};
            if (stage_reg[4])
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Hold the operand, advance the pipeline every cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= operand;
        end
        qhi_reg <= prod_hi[P1_W-1:S1];
        qlo_reg <= prod_lo[P1_W-1:S1];
        rhi_reg <= rhi_full[BKT_W-1:0];
        rlo_reg <= rlo_full[BKT_W-1:0];
        t_reg   <= t_sum;
        qt_reg  <= prod_t[P2_W-1:S2];
        rem_reg <= rt_full[BKT_W-1:0];
    end

    assign done   = done_reg;
    assign result = rem_reg;

    a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !done_reg)
        else $error("remainder reported done right after start");

    a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg != '0) |-> !done_reg)
        else $error("remainder busy and done together");

    a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stage_reg))
        else $error("remainder pipeline holds more than one word");

endmodule

/* rtl/core/lhc_datapath.sv */
`timescale 1ns / 1ps
module lhc_datapath #(
    parameter int ENTRY_COUNT      = lhc_pkg::DEF_ENTRY_COUNT,
    parameter int BUCKET_COUNT     = lhc_pkg::DEF_BUCKET_COUNT,
    parameter int SLOTS_PER_BUCKET = lhc_pkg::DEF_SLOTS_PER_BUCKET
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lhc_pkg::cmd_t cmd,
    output lhc_pkg::sts_t sts,
    input  logic [31:0]   in_data,
    input  logic          cfg_valid,
    input  logic [15:0]   cfg_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_data,
    output logic [1:0]    out_user
);
    import lhc_pkg::*;

    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int BKT_W       = $clog2(BUCKET_COUNT);
    localparam int SLOT_W      = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SLOT_DEPTH  = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int ADDR_W      = $clog2(SLOT_DEPTH);
    localparam int INIT_N      = (ENTRY_COUNT > SLOT_DEPTH) ? ENTRY_COUNT : SLOT_DEPTH;
    localparam int INIT_W      = $clog2(INIT_N);
    localparam int ENT_WORD_W  = CNT_W + 2 * KEY_W;
    localparam int SLOT_WORD_W = IDX_W + 1;

    // Entry word {count, dep, id}, slot word {valid, index}
    logic [ENT_WORD_W-1:0]  ent_mem  [ENTRY_COUNT];
    logic [SLOT_WORD_W-1:0] slot_mem [SLOT_DEPTH];

    logic [CNT_W-1:0]       limit_reg;
    logic [INIT_W-1:0]      init_cnt_reg;
    logic [KEY_W-1:0]       key_dep_reg;
    logic [KEY_W-1:0]       key_id_reg;
    logic [BKT_W-1:0]       bkt_new_reg;
    logic [BKT_W-1:0]       bkt_old_reg;
    logic [SLOT_W-1:0]      slot_cnt_reg;
    logic [ADDR_W-1:0]      slot_addr_reg;
    logic [SLOT_WORD_W-1:0] slot_q_reg;
    logic [ENT_WORD_W-1:0]  ent_q_reg;
    logic [IDX_W-1:0]       ent_cnt_reg;
    logic [IDX_W-1:0]       ent_q_addr_reg;
    logic                   cmp_valid_reg;
    logic [CNT_W-1:0]       best_reg;
    logic                   have_reg;
    logic [IDX_W-1:0]       vict_reg;
    logic [KEY_W-1:0]       vict_dep_reg;
    logic [KEY_W-1:0]       vict_id_reg;
    logic                   res_hit_reg;
    logic                   res_ok_reg;
    logic [IDX_W-1:0]       res_idx_reg;
    logic [CNT_W-1:0]       res_cnt_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic                   out_ok_reg;
    logic [OUT_IDX_W-1:0]   out_idx_reg;
    logic [CNT_W-1:0]       out_cnt_reg;

    logic                   mod_start;
    logic [PROD_W-1:0]      mod_operand;
    logic                   mod_done;
    logic [BKT_W-1:0]       mod_result;
    logic [BKT_W-1:0]       rd_bkt;
    logic [ADDR_W-1:0]      slot_raddr;
    logic                   ent_we;
    logic [IDX_W-1:0]       ent_waddr;
    logic [ENT_WORD_W-1:0]  ent_wdata;
    logic                   slot_we;
    logic [ADDR_W-1:0]      slot_waddr;
    logic [SLOT_WORD_W-1:0] slot_wdata;
    logic                   ent_re;
    logic [IDX_W-1:0]       ent_raddr;
    logic [CNT_W-1:0]       q_cnt;
    logic [KEY_W-1:0]       q_dep;
    logic [KEY_W-1:0]       q_id;
    logic [IDX_W-1:0]       q_slot_idx;
    logic                   q_slot_valid;

    assign q_id         = ent_q_reg[KEY_W-1:0];
    assign q_dep        = ent_q_reg[2*KEY_W-1:KEY_W];
    assign q_cnt        = ent_q_reg[ENT_WORD_W-1:2*KEY_W];
    assign q_slot_idx   = slot_q_reg[IDX_W-1:0];
    assign q_slot_valid = slot_q_reg[IDX_W];

    // Bucket index: one multiply, then the shared remainder unit
    assign mod_start   = (cmd.op == OP_LOAD) || (cmd.op == OP_MOD_OLD);
    assign mod_operand = (cmd.op == OP_LOAD)
                       ? PROD_W'(in_data[KEY_W-1:0]) * PROD_W'(in_data[2*KEY_W-1:KEY_W])
                       : PROD_W'(vict_dep_reg) * PROD_W'(vict_id_reg);

    lhc_mod #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .operand (mod_operand),
        .done    (mod_done),
        .result  (mod_result)
    );

    // Slot read address within the chosen bucket
    assign rd_bkt     = (cmd.op == OP_RD_OLD) ? bkt_old_reg : bkt_new_reg;
    assign slot_raddr = ADDR_W'(rd_bkt) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(slot_cnt_reg);

    // Write port selection for both stores
    always_comb
    begin
        ent_we     = 1'b0;
        ent_waddr  = vict_reg;
        ent_wdata  = {sat_inc(best_reg), key_dep_reg, key_id_reg};
        slot_we    = 1'b0;
        slot_waddr = slot_addr_reg;
        slot_wdata = '0;
        unique case (cmd.op)
            OP_INIT:
            begin
                ent_we     = (32'(init_cnt_reg) < ENTRY_COUNT);
                ent_waddr  = init_cnt_reg[IDX_W-1:0];
                ent_wdata  = {RESET_COUNT,
                              KEY_W'(32'(init_cnt_reg) * RESET_DEP_STEP),
                              KEY_W'(init_cnt_reg)};
                slot_we    = (32'(init_cnt_reg) < SLOT_DEPTH);
                slot_waddr = init_cnt_reg[ADDR_W-1:0];
            end
            OP_HIT:
            begin
                ent_we    = 1'b1;
                ent_waddr = q_slot_idx;
                ent_wdata = {sat_inc(q_cnt), q_dep, q_id};
            end
            OP_REKEY:
            begin
                ent_we = 1'b1;
            end
            OP_UNMAP:
            begin
                slot_we = 1'b1;
            end
            OP_MAP:
            begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, vict_reg};
            end
            default:
            begin
                ent_we = 1'b0;
            end
        endcase
    end

    assign ent_re    = (cmd.op == OP_ENT_RD) || (cmd.op == OP_VSCAN);
    assign ent_raddr = (cmd.op == OP_ENT_RD) ? q_slot_idx : ent_cnt_reg;

    // Entry store
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_q_reg <= ent_mem[ent_raddr];
        end
    end

    // Slot store
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if ((cmd.op == OP_RD_NEW) || (cmd.op == OP_RD_OLD))
        begin
            slot_q_reg <= slot_mem[slot_raddr];
        end
    end

    // Control counters, limit register and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= RESET_LIMIT;
            init_cnt_reg  <= '0;
            slot_cnt_reg  <= '0;
            ent_cnt_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.op == OP_INIT)
            begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if ((cmd.op == OP_BKT_NEW) || (cmd.op == OP_BKT_OLD) || (cmd.op == OP_REKEY))
            begin
                slot_cnt_reg <= '0;
            end
            else if (cmd.op == OP_NEXT)
            begin
                slot_cnt_reg <= slot_cnt_reg + 1'b1;
            end
            if (cmd.op == OP_VINIT)
            begin
                ent_cnt_reg <= '0;
                have_reg    <= 1'b0;
            end
            else if (cmd.op == OP_VSCAN)
            begin
                ent_cnt_reg <= ent_cnt_reg + 1'b1;
            end
            if (cmp_valid_reg && (q_cnt < best_reg))
            begin
                have_reg <= 1'b1;
            end
            cmp_valid_reg <= (cmd.op == OP_VSCAN);
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Keys, buckets, victim tracking and result words
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            key_dep_reg <= in_data[KEY_W-1:0];
            key_id_reg  <= in_data[2*KEY_W-1:KEY_W];
        end
        if (cmd.op == OP_BKT_NEW)
        begin
            bkt_new_reg <= mod_result;
        end
        if (cmd.op == OP_BKT_OLD)
        begin
            bkt_old_reg <= mod_result;
        end
        if ((cmd.op == OP_RD_NEW) || (cmd.op == OP_RD_OLD))
        begin
            slot_addr_reg <= slot_raddr;
        end
        ent_q_addr_reg <= ent_cnt_reg;
        if (cmd.op == OP_VINIT)
        begin
            best_reg <= limit_reg;
        end
        else if (cmp_valid_reg && (q_cnt < best_reg))
        begin
            best_reg     <= q_cnt;
            vict_reg     <= ent_q_addr_reg;
            vict_dep_reg <= q_dep;
            vict_id_reg  <= q_id;
        end
        unique case (cmd.op)
            OP_HIT:
            begin
                res_hit_reg <= 1'b1;
                res_ok_reg  <= 1'b1;
                res_idx_reg <= q_slot_idx;
                res_cnt_reg <= sat_inc(q_cnt);
            end
            OP_REKEY:
            begin
                res_cnt_reg <= sat_inc(best_reg);
            end
            OP_MAP:
            begin
                res_hit_reg <= 1'b0;
                res_ok_reg  <= 1'b1;
                res_idx_reg <= vict_reg;
            end
            OP_FAIL:
            begin
                res_hit_reg <= 1'b0;
                res_ok_reg  <= 1'b0;
                res_idx_reg <= '0;
                res_cnt_reg <= '0;
            end
            default:
            begin
                res_hit_reg <= res_hit_reg;
            end
        endcase
        if (cmd.op == OP_EMIT)
        begin
            out_hit_reg <= res_hit_reg;
            out_ok_reg  <= res_ok_reg;
            out_idx_reg <= OUT_IDX_W'(res_idx_reg);
            out_cnt_reg <= res_cnt_reg;
        end
    end

    assign sts.init_last   = (init_cnt_reg == INIT_W'(INIT_N - 1));
    assign sts.mod_done    = mod_done;
    assign sts.slot_last   = (slot_cnt_reg == SLOT_W'(SLOTS_PER_BUCKET - 1));
    assign sts.slot_valid  = q_slot_valid;
    assign sts.key_match   = (q_dep == key_dep_reg) && (q_id == key_id_reg);
    assign sts.idx_match   = (q_slot_idx == vict_reg);
    assign sts.ent_last    = (ent_cnt_reg == IDX_W'(ENTRY_COUNT - 1));
    assign sts.have_victim = have_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {{(32 - CNT_W - OUT_IDX_W){1'b0}}, out_cnt_reg, out_idx_reg};
    assign out_user  = {out_ok_reg, out_hit_reg};

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_idx_reg == '0 && out_cnt_reg == '0))
        else $error("failed lookup returned a non-zero word");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_hit_reg || out_ok_reg))
        else $error("hit reported without ok");

endmodule

/* rtl/core/lhc_ctrl.sv */
`timescale 1ns / 1ps
module lhc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lhc_pkg::sts_t sts,
    output lhc_pkg::cmd_t cmd
);
    import lhc_pkg::*;

    typedef enum logic [15:0] {
        S_INIT     = 16'h0001,
        S_IDLE     = 16'h0002,
        S_WAIT_NEW = 16'h0004,
        S_HRD      = 16'h0008,
        S_HSLOT    = 16'h0010,
        S_HCMP     = 16'h0020,
        S_VSCAN    = 16'h0040,
        S_VTAIL    = 16'h0080,
        S_VCHK     = 16'h0100,
        S_WAIT_OLD = 16'h0200,
        S_URD      = 16'h0400,
        S_USLOT    = 16'h0800,
        S_REKEY    = 16'h1000,
        S_MRD      = 16'h2000,
        S_MSLOT    = 16'h4000,
        S_RES      = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one lookup through hit scan, victim scan, unmap and map
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_INIT;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_WAIT_NEW;
                end
            end
            S_WAIT_NEW:
            begin
                if (sts.mod_done)
                begin
                    cmd.op     = OP_BKT_NEW;
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                cmd.op     = OP_RD_NEW;
                state_next = S_HSLOT;
            end
            S_HSLOT:
            begin
                if (sts.slot_valid)
                begin
                    cmd.op     = OP_ENT_RD;
                    state_next = S_HCMP;
                end
                else if (sts.slot_last)
                begin
                    cmd.op     = OP_VINIT;
                    state_next = S_VSCAN;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_HRD;
                end
            end
            S_HCMP:
            begin
                if (sts.key_match)
                begin
                    cmd.op     = OP_HIT;
                    state_next = S_RES;
                end
                else if (sts.slot_last)
                begin
                    cmd.op     = OP_VINIT;
                    state_next = S_VSCAN;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_HRD;
                end
            end
            S_VSCAN:
            begin
                cmd.op = OP_VSCAN;
                if (sts.ent_last)
                begin
                    state_next = S_VTAIL;
                end
            end
            S_VTAIL:
            begin
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                if (sts.have_victim)
                begin
                    cmd.op     = OP_MOD_OLD;
                    state_next = S_WAIT_OLD;
                end
                else
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_RES;
                end
            end
            S_WAIT_OLD:
            begin
                if (sts.mod_done)
                begin
                    cmd.op     = OP_BKT_OLD;
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                cmd.op     = OP_RD_OLD;
                state_next = S_USLOT;
            end
            S_USLOT:
            begin
                if (sts.slot_valid && sts.idx_match)
                begin
                    cmd.op     = OP_UNMAP;
                    state_next = S_REKEY;
                end
                else if (sts.slot_last)
                begin
                    state_next = S_REKEY;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_URD;
                end
            end
            S_REKEY:
            begin
                cmd.op     = OP_REKEY;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                cmd.op     = OP_RD_NEW;
                state_next = S_MSLOT;
            end
            S_MSLOT:
            begin
                if (!sts.slot_valid)
                begin
                    cmd.op     = OP_MAP;
                    state_next = S_RES;
                end
                else if (sts.slot_last)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_RES;
                end
                else
                begin
                    cmd.op     = OP_NEXT;
                    state_next = S_MRD;
                end
            end
            S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while a lookup is in flight");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> sts.out_free)
        else $error("result issued over an untaken word");

endmodule

/* rtl/core/lfu_hashed_cache_lookup_top.sv */
`timescale 1ns / 1ps
// Channel   Direction  Signals                          Contents
// s_axis    in         tvalid tready tdata[31:0]        lookup key
// m_axis    out        tvalid tready tdata[31:0] tuser  lookup result
// cfg       in         valid ready data[15:0]           victim count limit
//
// After reset a clearing pass over max(ENTRY_COUNT, BUCKET_COUNT*SLOTS_PER_BUCKET)
// addresses (1984 by default) fills the entry store and empties the slot store.
// A lookup reduces the key product to a bucket in the pipelined remainder unit and scans
// that bucket's slots for a hit; a miss adds a scan of all entries for the victim, the
// victim's old bucket, and a slot scan each to unmap the victim and to map the new key.
// One lookup is in flight at a time; a finished word waits in the output register while
// the next key is taken.
module lfu_hashed_cache_lookup_top #(
    parameter int ENTRY_COUNT      = lhc_pkg::DEF_ENTRY_COUNT,
    parameter int BUCKET_COUNT     = lhc_pkg::DEF_BUCKET_COUNT,
    parameter int SLOTS_PER_BUCKET = lhc_pkg::DEF_SLOTS_PER_BUCKET
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // dep_key[14:0], id_key[29:15]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // entry_index[9:0], use_count[25:10]
    output logic [1:0]  m_axis_tuser,  // hit[0], ok[1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data       // victim_count_limit
);
    import lhc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lhc_datapath #(
        .ENTRY_COUNT      (ENTRY_COUNT),
        .BUCKET_COUNT     (BUCKET_COUNT),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
